### rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    // Input field width on the stream bus
    localparam int IN_FIELD_W = 16;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 8;
    localparam int RES_W     = 4;

    // Input field positions in the slave tdata
    localparam int OP_LSB   = 0;
    localparam int PX_LSB   = 2;
    localparam int PY_LSB   = 18;
    localparam int PZ_LSB   = 34;
    localparam int SX_LSB   = 50;
    localparam int SY_LSB   = 66;
    localparam int SZ_LSB   = 82;
    localparam int FRAG_BIT = 98;

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Configuration register
    localparam int         PCT_W           = 7;
    localparam logic [6:0] PCT_RESET       = 7'd70;
    localparam int         APB_AW          = 3;
    localparam int         APB_DW          = 32;
    localparam logic       REG_SUPPORT_PCT = 1'b0;

    // Scan status from the pair unit to the sequencer
    typedef struct packed {
        logic busy;
        logic clash;
        logic frag_bad;
    } t_scan_status;

    // Result item, no_overlap in the lowest bit
    typedef struct packed {
        logic add_accepted;
        logic support_ok;
        logic fragility_ok;
        logic no_overlap;
    } t_result;

endpackage

`default_nettype wire

### rtl/bpc_ram.sv
`default_nettype none

module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/bpc_pair_unit.sv
`default_nettype none

module bpc_pair_unit #(
    parameter int CW    = 16,
    parameter int CNT_W = 9
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_valid,
    input  wire logic [6*CW:0]           i_entry,
    input  wire logic [CW-1:0]           i_px,
    input  wire logic [CW-1:0]           i_py,
    input  wire logic [CW-1:0]           i_pz,
    input  wire logic [CW:0]             i_ex,
    input  wire logic [CW:0]             i_ey,
    input  wire logic [CW:0]             i_ez,
    input  wire logic                    i_on_floor,
    output bpc_pkg::t_scan_status        o_status,
    output logic      [2*CW+CNT_W-1:0]   o_sum
);
    import bpc_pkg::*;

    localparam int EW     = CW + 1;
    localparam int AREA_W = 2 * CW;
    localparam int SUM_W  = AREA_W + CNT_W;

    // Stage 1: far corners of the stored box
    logic [CW-1:0] r_qx, r_qy, r_qz;
    logic [EW-1:0] r_fx, r_fy, r_fz;
    logic          r_frag1, r_s1_vld;

    // Stage 2: overlap flags and XY overlap lengths
    logic [CW-1:0] r_ox, r_oy;
    logic          r_hit2, r_rest2, r_frag2, r_s2_vld;

    // Stage 3: overlap area
    logic [AREA_W-1:0] r_area;
    logic              r_hit3, r_rest3, r_frag3, r_s3_vld;

    // Accumulators
    logic             r_clash, r_fbad;
    logic [SUM_W-1:0] r_sum;

    logic [CW-1:0] qx, qy, qz, sx, sy, sz;
    logic          mx, my, mz, top;
    logic [CW-1:0] lo_x, lo_y;
    logic [EW-1:0] hi_x, hi_y;

    assign qx = i_entry[0*CW +: CW];
    assign qy = i_entry[1*CW +: CW];
    assign qz = i_entry[2*CW +: CW];
    assign sx = i_entry[3*CW +: CW];
    assign sy = i_entry[4*CW +: CW];
    assign sz = i_entry[5*CW +: CW];

    // Open-interval tests against the candidate
    always_comb begin
        mx   = (EW'(i_px) < r_fx) && (i_ex > EW'(r_qx));
        my   = (EW'(i_py) < r_fy) && (i_ey > EW'(r_qy));
        mz   = (EW'(i_pz) < r_fz) && (i_ez > EW'(r_qz));
        top  = (EW'(i_pz) == r_fz);
        lo_x = (i_px > r_qx) ? i_px : r_qx;
        lo_y = (i_py > r_qy) ? i_py : r_qy;
        hi_x = (i_ex < r_fx) ? i_ex : r_fx;
        hi_y = (i_ey < r_fy) ? i_ey : r_fy;
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_qx    <= qx;
        r_qy    <= qy;
        r_qz    <= qz;
        r_fx    <= EW'(qx) + EW'(sx);
        r_fy    <= EW'(qy) + EW'(sy);
        r_fz    <= EW'(qz) + EW'(sz);
        r_frag1 <= i_entry[6*CW];

        r_hit2  <= mx && my && mz;
        r_rest2 <= mx && my && top && !i_on_floor;
        r_frag2 <= r_frag1;
        r_ox    <= CW'(hi_x - EW'(lo_x));
        r_oy    <= CW'(hi_y - EW'(lo_y));

        r_area  <= AREA_W'(r_ox) * AREA_W'(r_oy);
        r_hit3  <= r_hit2;
        r_rest3 <= r_rest2;
        r_frag3 <= r_frag2;
    end

    // Accumulate verdicts over the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_clash <= 1'b0;
            r_fbad  <= 1'b0;
            r_sum   <= '0;
        end else if (r_s3_vld) begin
            r_clash <= r_clash | r_hit3;
            r_fbad  <= r_fbad | (r_rest3 & r_frag3);
            if (r_rest3) begin
                r_sum <= r_sum + SUM_W'(r_area);
            end
        end
    end

    assign o_status.busy     = r_s1_vld | r_s2_vld | r_s3_vld;
    assign o_status.clash    = r_clash;
    assign o_status.frag_bad = r_fbad;
    assign o_sum             = r_sum;

endmodule

`default_nettype wire

### rtl/box_placement_checker.sv
// Channel   Dir  Handshake                   Payload (low bit first)
// s (items) in   i_s_tvalid / o_s_tready     operation, pos_x..z, size_x..z, is_fragile
// m (items) out  o_m_tvalid / i_m_tready     no_overlap, fragility_ok, support_ok,
//                                            add_accepted
// cfg (APB) in   psel, penable, pwrite       support_percent at address 0
//
// A check runs S_SCAN over the n stored boxes (skipped on an empty table), then S_DRAIN,
// S_RAT1, S_RAT2 and S_FINISH; the scan reads one table entry per cycle through the single
// read port. Add, clear and unused codes go from accept straight to S_FINISH.
// o_s_tready is high only while idle; a stalled result register holds the next item back.
// The result register holds the last item while a new one is accepted and worked on.
// Reset is synchronous, active low; it empties the table and sets support_percent to 70.
`default_nettype none

module box_placement_checker #(
    parameter int MAX_BOXES  = 256,
    parameter int COORD_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // operation[1:0], pos_x[17:2], pos_y[33:18], pos_z[49:34], size_x[65:50],
    // size_y[81:66], size_z[97:82], is_fragile[98], zero[103:99]
    input  wire logic [bpc_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // no_overlap[0], fragility_ok[1], support_ok[2], add_accepted[3], zero[7:4]
    output logic      [bpc_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bpc_pkg::APB_AW-1:0]       paddr,
    input  wire logic [bpc_pkg::APB_DW-1:0]       pwdata,
    output logic      [bpc_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready
);
    import bpc_pkg::*;

    localparam int CW      = COORD_BITS;
    localparam int EW      = CW + 1;
    localparam int AW      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int AREA_W  = 2 * CW;
    localparam int SUM_W   = AREA_W + CNT_W;
    localparam int TGT_W   = AREA_W + PCT_W;
    localparam int PROD_W  = SUM_W + PCT_W;
    localparam int ENTRY_W = 6 * CW + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_RAT1   = 6'b001000,
        S_RAT2   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [PCT_W-1:0]  r_pct;
    logic              r_v1;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    t_result           r_res, n_res;

    // Candidate registers
    logic [CW-1:0]     r_px, r_py, r_pz, r_sx, r_sy;
    logic [EW-1:0]     r_ex, r_ey, r_ez;
    logic              r_floor;

    // Ratio test registers
    logic [AREA_W-1:0] r_base;
    logic [TGT_W-1:0]  r_target;
    logic [PROD_W-1:0] r_t;

    logic              accept, full, issue, start;
    logic [1:0]        in_op;
    logic [CW-1:0]     in_px, in_py, in_pz, in_sx, in_sy, in_sz;
    logic [ENTRY_W-1:0] wr_entry, rd_entry;
    logic              cfg_wr, reg_hit, ge;
    t_scan_status      status;
    logic [SUM_W-1:0]  sum;

    // Unpack the input item
    assign in_op = i_s_tdata[OP_LSB +: 2];
    assign in_px = CW'(i_s_tdata[PX_LSB +: IN_FIELD_W]);
    assign in_py = CW'(i_s_tdata[PY_LSB +: IN_FIELD_W]);
    assign in_pz = CW'(i_s_tdata[PZ_LSB +: IN_FIELD_W]);
    assign in_sx = CW'(i_s_tdata[SX_LSB +: IN_FIELD_W]);
    assign in_sy = CW'(i_s_tdata[SY_LSB +: IN_FIELD_W]);
    assign in_sz = CW'(i_s_tdata[SZ_LSB +: IN_FIELD_W]);
    assign wr_entry = {i_s_tdata[FRAG_BIT], in_sz, in_sy, in_sx, in_pz, in_py, in_px};

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign full       = (r_cnt == CNT_W'(MAX_BOXES));
    assign issue      = (r_state == S_SCAN);
    assign start      = accept && (in_op == OP_CHECK);

    // Box table
    bpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && (in_op == OP_ADD) && !full),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_entry)
    );

    // Per-box overlap and support evaluation
    bpc_pair_unit #(
        .CW    (CW),
        .CNT_W (CNT_W)
    ) u_pair (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_valid    (r_v1),
        .i_entry    (rd_entry),
        .i_px       (r_px),
        .i_py       (r_py),
        .i_pz       (r_pz),
        .i_ex       (r_ex),
        .i_ey       (r_ey),
        .i_ez       (r_ez),
        .i_on_floor (r_floor),
        .o_status   (status),
        .o_sum      (sum)
    );

    // Configuration port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_SUPPORT_PCT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? APB_DW'(r_pct) : '0;

    // Supported area times 100 against percent times base
    assign ge = (r_t + (PROD_W'(sum) << 2)) >= PROD_W'(r_target);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_FINISH;
                    unique case (in_op)
                        OP_ADD: begin
                            if (!full) begin
                                n_cnt            = r_cnt + 1'b1;
                                n_res.add_accepted = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        OP_CHECK: begin
                            n_idx   = '0;
                            n_state = (r_cnt == '0) ? S_DRAIN : S_SCAN;
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if ((r_idx + 1'b1) == r_cnt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !status.busy) begin
                    n_state = S_RAT1;
                end
            end
            S_RAT1: begin
                n_state = S_RAT2;
            end
            S_RAT2: begin
                n_res.no_overlap   = !status.clash;
                n_res.fragility_ok = r_floor || !status.frag_bad;
                n_res.support_ok   = r_floor || ge;
                n_state            = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pct       <= PCT_RESET;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_v1        <= issue;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_pct <= pwdata[PCT_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_out    <= n_out;
        r_base   <= AREA_W'(r_sx) * AREA_W'(r_sy);
        r_target <= TGT_W'(r_base) * TGT_W'(r_pct);
        r_t      <= (PROD_W'(sum) << 6) + (PROD_W'(sum) << 5);
        if (start) begin
            r_px    <= in_px;
            r_py    <= in_py;
            r_pz    <= in_pz;
            r_sx    <= in_sx;
            r_sy    <= in_sy;
            r_ex    <= EW'(in_px) + EW'(in_sx);
            r_ey    <= EW'(in_py) + EW'(in_sy);
            r_ez    <= EW'(in_pz) + EW'(in_sz);
            r_floor <= (in_pz == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, r_out};

endmodule

`default_nettype wire

### rtl/bpc_checker.sv
`default_nettype none

module bpc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          i_s_tready,
    input wire logic                          i_m_tvalid,
    input wire logic                          i_m_tready,
    // no_overlap[0], fragility_ok[1], support_ok[2], add_accepted[3], zero[7:4]
    input wire logic [bpc_pkg::M_TDATA_W-1:0] i_m_tdata
);

    // Ready drops once an item is taken in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("ready stayed high after an item was accepted");

    // Add results carry no check verdicts
    a_add_fields_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[3]) |-> (i_m_tdata[2:0] == 3'b000))
        else $error("add result carries check verdicts");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // Reset leaves the block idle
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_s_tready)
        else $error("block not ready after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind box_placement_checker bpc_checker u_bpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire
